// ===== src/chromaticity_color_classifier_macros.svh =====
// Assertion macros shared by the chromaticity classifier RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef CHROMATICITY_COLOR_CLASSIFIER_MACROS_SVH
`define CHROMATICITY_COLOR_CLASSIFIER_MACROS_SVH
`ifndef ASSERT_OFF
`define CCC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CCC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define CCC_ASSERT(label, clk, rst_n, prop, msg)
`define CCC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== src/ccc_pkg.sv =====
// Package for the chromaticity classifier: payload structs, constants and
// the controller/datapath command and status structs. No dependencies.
package ccc_pkg;
  localparam int NUM_REFS  = 10;
  localparam int IDX_W     = 4;
  localparam int PCT_W     = 7;
  localparam int RAW_W     = 10;
  localparam int SUM_W     = 17;
  localparam int CNT_W     = 7;
  localparam int DIV_STEPS = 17;
  localparam logic [CNT_W-1:0] DEFAULT_SAMPLES = 7'd5;
  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic             command;
    logic [IDX_W-1:0] entry_index;
    logic [PCT_W-1:0] ref_red_pct;
    logic [PCT_W-1:0] ref_green_pct;
    logic [PCT_W-1:0] ref_blue_pct;
    logic [PCT_W-1:0] tolerance_pct;
    logic [RAW_W-1:0] raw_red;
    logic [RAW_W-1:0] raw_green;
    logic [RAW_W-1:0] raw_blue;
    logic [RAW_W-1:0] raw_ambient;
  } in_item_t;

  typedef struct packed {
    logic             matched;
    logic [IDX_W-1:0] class_index;
    logic [RAW_W-1:0] avg_red;
    logic [RAW_W-1:0] avg_green;
    logic [RAW_W-1:0] avg_blue;
    logic [RAW_W-1:0] avg_ambient;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accum;      // add the held reading into the sums (clear them if it completes an average)
    logic avg_start;  // copy the four average quotients
    logic div_step;   // one restoring division step
    logic pct_start;  // load the three percentage dividers
    logic scan_start; // reset the table scan
    logic scan_step;  // test one reference entry
    logic out_load;   // copy the result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic avg_due;   // this reading completes an average
    logic sum_zero;  // RGB sum of the averages is zero
    logic scan_done; // a match was found or every entry was tested
  } dp_sts_t;
endpackage

// ===== src/ccc_datapath.sv =====
// Datapath of the chromaticity classifier: sums, shared serial dividers,
// reference table and scan. Depends on ccc_pkg and the macro header.
`include "chromaticity_color_classifier_macros.svh"
module ccc_datapath
  import ccc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             tbl_we,
  input  in_item_t         item,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts,
  output out_item_t        result
);
  logic [CNT_W-1:0] samples_r;
  logic [SUM_W-1:0] sum_r [4];
  logic [CNT_W-1:0] count_r;
  logic [PCT_W-1:0] tbl_r [NUM_REFS][4];
  logic [SUM_W-1:0] quo_r [4];
  logic [SUM_W-1:0] rem_r [4];
  logic [SUM_W:0]   div_r;
  logic [RAW_W-1:0] avg_r [4];
  logic [IDX_W-1:0] scan_r;
  logic             found_r;
  logic             done_r;
  logic [RAW_W+1:0] rgb_sum;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] target;
  logic [SUM_W-1:0] rem_sh [4];
  logic [SUM_W:0]   rem_try [4];
  logic             ok [3];
  logic [PCT_W:0]   hi_lim [3];
  logic signed [PCT_W+1:0] lo_lim [3];
  logic [PCT_W-1:0] pct [3];
  logic             entry_hit;
  out_item_t        out_r;

  assign count_inc = count_r + 1'b1;
  assign target    = (samples_r == '0) ? 7'd1 : samples_r;
  assign rgb_sum   = {2'b0, avg_r[0]} + {2'b0, avg_r[1]} + {2'b0, avg_r[2]};
  assign sts.avg_due   = (count_inc == '0) || (count_inc >= target);
  assign sts.sum_zero  = (rgb_sum == '0);
  assign sts.scan_done = done_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rem_sh[i]  = {rem_r[i][SUM_W-2:0], quo_r[i][SUM_W-1]};
      rem_try[i] = {1'b0, rem_sh[i]} - div_r;
    end
    for (int i = 0; i < 3; i++) begin
      pct[i]    = quo_r[i][PCT_W-1:0];
      hi_lim[i] = {1'b0, tbl_r[scan_r][i]} + {1'b0, tbl_r[scan_r][3]};
      lo_lim[i] = $signed({2'b0, tbl_r[scan_r][i]}) - $signed({2'b0, tbl_r[scan_r][3]});
      ok[i]     = ({1'b0, pct[i]} <= hi_lim[i]) && (lo_lim[i] <= $signed({2'b0, pct[i]}));
    end
    entry_hit = ok[0] && ok[1] && ok[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samples_r <= DEFAULT_SAMPLES;
      count_r   <= '0;
      for (int i = 0; i < 4; i++) sum_r[i] <= '0;
      for (int k = 0; k < NUM_REFS; k++)
        for (int j = 0; j < 4; j++) tbl_r[k][j] <= '0;
      found_r <= 1'b0;
      done_r <= 1'b0;
      scan_r <= '0;
    end else begin
      if (cfg_we) samples_r <= cfg_wdata;
      if (tbl_we && item.entry_index < IDX_W'(NUM_REFS)) begin
        tbl_r[item.entry_index][0] <= item.ref_red_pct;
        tbl_r[item.entry_index][1] <= item.ref_green_pct;
        tbl_r[item.entry_index][2] <= item.ref_blue_pct;
        tbl_r[item.entry_index][3] <= item.tolerance_pct;
      end
      if (cmd.accum) begin
        if (sts.avg_due) begin
          for (int i = 0; i < 4; i++) sum_r[i] <= '0;
          count_r <= '0;
        end else begin
          sum_r[0] <= sum_r[0] + SUM_W'(item.raw_red);
          sum_r[1] <= sum_r[1] + SUM_W'(item.raw_green);
          sum_r[2] <= sum_r[2] + SUM_W'(item.raw_blue);
          sum_r[3] <= sum_r[3] + SUM_W'(item.raw_ambient);
          count_r  <= count_inc;
        end
      end
      if (cmd.scan_start) begin
        scan_r <= '0;
        found_r <= 1'b0;
        done_r <= 1'b0;
      end else if (cmd.scan_step && !done_r) begin
        if (entry_hit) begin
          found_r <= 1'b1;
          done_r  <= 1'b1;
        end else if (scan_r == IDX_W'(NUM_REFS - 1)) begin
          done_r <= 1'b1;
        end else begin
          scan_r <= scan_r + 1'b1;
        end
      end
    end
  end

  // The dividers are loaded with the completed sums, the new reading
  // included, in the cycle the reading is taken; avg_start copies the
  // average quotients once every step is done.
  always_ff @(posedge clk) begin
    if (cmd.accum && sts.avg_due) begin
      quo_r[0] <= sum_r[0] + SUM_W'(item.raw_red);
      quo_r[1] <= sum_r[1] + SUM_W'(item.raw_green);
      quo_r[2] <= sum_r[2] + SUM_W'(item.raw_blue);
      quo_r[3] <= sum_r[3] + SUM_W'(item.raw_ambient);
      for (int i = 0; i < 4; i++) rem_r[i] <= '0;
      div_r <= (count_inc == '0) ? (SUM_W+1)'(128) : (SUM_W+1)'(count_inc);
    end else if (cmd.pct_start) begin
      for (int i = 0; i < 3; i++) begin
        quo_r[i] <= SUM_W'(avg_r[i]) * SUM_W'(PCT_SCALE);
        rem_r[i] <= '0;
      end
      div_r <= (SUM_W+1)'(rgb_sum);
    end else if (cmd.div_step) begin
      for (int i = 0; i < 4; i++) begin
        if (!rem_try[i][SUM_W]) begin
          rem_r[i] <= rem_try[i][SUM_W-1:0];
          quo_r[i] <= {quo_r[i][SUM_W-2:0], 1'b1};
        end else begin
          rem_r[i] <= rem_sh[i];
          quo_r[i] <= {quo_r[i][SUM_W-2:0], 1'b0};
        end
      end
    end
    if (cmd.avg_start)
      for (int i = 0; i < 4; i++) avg_r[i] <= quo_r[i][RAW_W-1:0];
    if (cmd.out_load) begin
      out_r.matched     <= found_r && !sts.sum_zero;
      out_r.class_index <= (found_r && !sts.sum_zero) ? scan_r : '0;
      out_r.avg_red     <= avg_r[0];
      out_r.avg_green   <= avg_r[1];
      out_r.avg_blue    <= avg_r[2];
      out_r.avg_ambient <= avg_r[3];
    end
  end

  assign result = out_r;

  `CCC_ASSERT(a_found_done, clk, rst_n, found_r |-> done_r, "match without scan end")
  `CCC_ASSERT_NEXT(a_scan_start_clears, clk, rst_n, cmd.scan_start, !done_r && scan_r == '0, "scan did not restart")
  `CCC_ASSERT(a_scan_in_table, clk, rst_n, (scan_r < IDX_W'(NUM_REFS)), "scan index left the table")
endmodule

// ===== src/ccc_ctrl.sv =====
// Controller of the chromaticity classifier: sequences accumulation, the
// two serial division passes and the table scan. Depends on ccc_pkg.
`include "chromaticity_color_classifier_macros.svh"
module ccc_ctrl
  import ccc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    in_cmd,
  output logic    tbl_we,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_AVG   = 7'b0000010,
    S_AVGLD = 7'b0000100,
    S_PCT   = 7'b0001000,
    S_SCAN0 = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  // The result register parts the two sides: a waiting result does not
  // block input, only the next result waits for it to be read.
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign tbl_we    = accept && (in_cmd == CMD_LOAD);

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    out_valid_nxt = out_valid_r;
    cmd = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_cmd == CMD_READ) begin
          cmd.accum = 1'b1;
          if (sts.avg_due) begin
            state_nxt = S_AVG;
            step_nxt = '0;
          end
        end
      end
      S_AVG: begin
        cmd.div_step = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == 5'(DIV_STEPS - 1)) state_nxt = S_AVGLD;
      end
      S_AVGLD: begin
        cmd.avg_start = 1'b1;
        state_nxt = S_PCT;
        step_nxt = '0;
      end
      S_PCT: begin
        if (step_r == '0) cmd.pct_start = 1'b1;
        else cmd.div_step = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == 5'(DIV_STEPS)) state_nxt = S_SCAN0;
      end
      S_SCAN0: begin
        cmd.scan_start = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done || sts.sum_zero) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CCC_ASSERT(a_onehot, clk, rst_n, $onehot(state_r), "state not one-hot")
  `CCC_ASSERT_NEXT(a_out_after_load, clk, rst_n, cmd.out_load, out_valid_r, "result not shown")
  `CCC_ASSERT(a_no_accept_busy, clk, rst_n, (state_r != S_IDLE) |-> !in_ready, "ready while busy")
endmodule

// ===== src/chromaticity_color_classifier.sv =====
// Chromaticity color classifier: takes reference loads and sensor readings,
// averages readings and classifies the normalized RGB shares against a table.
// Depends on ccc_pkg, ccc_ctrl and ccc_datapath.
//
// A load item writes one reference entry in the cycle it is accepted. A
// reading that does not complete an average is taken while the block stays
// idle, so the next item can follow it. A reading that completes an average
// keeps the block busy until its result item is offered: 17 steps of the
// shared restoring divider form the four averages, avg_start copies them,
// pct_start loads the divider for the three percentages and 17 more steps
// form them, scan_start restarts the table scan, the scan tests one entry per
// cycle until a match or the last entry ends it (the scan is cut short with
// no match when the RGB sum is zero), and out_load loads the result register.
// No item is taken while that work runs. A waiting result does not block
// input; only the next completed average waits for it to be read, so output
// stalls add to that average's latency.
module chromaticity_color_classifier
  import ccc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    tbl_we;

  // The controller sequences every multi-cycle step of a completed average.
  ccc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_item.command), .tbl_we(tbl_we), .out_valid(out_valid),
    .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  // The datapath holds the sums, the table and the shared dividers.
  ccc_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .tbl_we(tbl_we), .item(in_item), .cmd(cmd), .sts(sts), .result(out_item)
  );
endmodule

// ===== tb/chromaticity_color_classifier_tb.sv =====
// Self-checking testbench for chromaticity_color_classifier: table loads,
// sensor readings, averaging and classification. Depends on ccc_pkg and the top module.
`timescale 1ns / 100ps

module chromaticity_color_classifier_tb;
  import ccc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 80;

  typedef struct packed {
    logic [PCT_W-1:0] red;
    logic [PCT_W-1:0] green;
    logic [PCT_W-1:0] blue;
    logic [PCT_W-1:0] tol;
  } ref_entry_t;

  // One row of the directed table; has_exp marks rows whose result is typed in.
  typedef struct {
    in_item_t  item;
    logic      has_exp;
    out_item_t exp;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_item = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_item;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  // Predictor state, mirroring the block.
  ref_entry_t       ref_table [NUM_REFS];
  logic [31:0]      sum_r, sum_g, sum_b, sum_a;
  logic [CNT_W-1:0] taken;
  logic [CNT_W-1:0] samples_cfg;

  // Typed-in expectation that travels with the item being driven.
  logic       cur_has_exp = 1'b0;
  out_item_t  cur_exp = '0;

  out_item_t  class_q[$];
  out_item_t  typed_q[$];   // typed-in expectations, parallel to class_q
  logic       typed_v[$];
  int         errors = 0;
  int         n_items = 0;
  int         n_results = 0;
  int         n_hits = 0;
  int         idle_cycles = 0;
  int         stall_left = 0;

  always #2 clk = ~clk;

  chromaticity_color_classifier i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  function automatic bit share_in_range(int pct, int r, int t);
    return (pct >= r - t) && (pct <= r + t);
  endfunction

  // Apply one accepted item to the predictor; returns 1 with res when it
  // completes an average.
  function automatic bit classify_item(in_item_t it, output out_item_t res);
    int unsigned n, ar, ag, ab, aa, rgb;
    int target, pr, pg, pb;
    res = '0;
    if (it.command == CMD_LOAD) begin
      if (it.entry_index < NUM_REFS)
        ref_table[it.entry_index] = '{it.ref_red_pct, it.ref_green_pct,
                                      it.ref_blue_pct, it.tolerance_pct};
      return 0;
    end
    sum_r += it.raw_red;
    sum_g += it.raw_green;
    sum_b += it.raw_blue;
    sum_a += it.raw_ambient;
    taken = taken + 1'b1;
    target = (samples_cfg == 0) ? 1 : samples_cfg;
    if (taken < target && taken != 0) return 0;
    n = (taken == 0) ? 128 : taken;
    ar = sum_r / n;
    ag = sum_g / n;
    ab = sum_b / n;
    aa = sum_a / n;
    sum_r = 0; sum_g = 0; sum_b = 0; sum_a = 0;
    taken = '0;
    res.avg_red = ar[RAW_W-1:0];
    res.avg_green = ag[RAW_W-1:0];
    res.avg_blue = ab[RAW_W-1:0];
    res.avg_ambient = aa[RAW_W-1:0];
    rgb = ar + ag + ab;
    if (rgb != 0) begin
      pr = ar * 100 / rgb;
      pg = ag * 100 / rgb;
      pb = ab * 100 / rgb;
      for (int k = 0; k < NUM_REFS; k++) begin
        if (share_in_range(pr, ref_table[k].red, ref_table[k].tol) &&
            share_in_range(pg, ref_table[k].green, ref_table[k].tol) &&
            share_in_range(pb, ref_table[k].blue, ref_table[k].tol)) begin
          res.matched = 1'b1;
          res.class_index = k[IDX_W-1:0];
          break;
        end
      end
    end
    return 1;
  endfunction

  // Compare every field of one result item with an expectation.
  task automatic check_fields(out_item_t e, out_item_t a);
    if (a.matched !== e.matched) begin
      $error("matched: expected %0d, got %0d", e.matched, a.matched);
      errors++;
    end
    if (a.class_index !== e.class_index) begin
      $error("class_index: expected %0d, got %0d", e.class_index, a.class_index);
      errors++;
    end
    if (a.avg_red !== e.avg_red) begin
      $error("avg_red: expected %0d, got %0d", e.avg_red, a.avg_red);
      errors++;
    end
    if (a.avg_green !== e.avg_green) begin
      $error("avg_green: expected %0d, got %0d", e.avg_green, a.avg_green);
      errors++;
    end
    if (a.avg_blue !== e.avg_blue) begin
      $error("avg_blue: expected %0d, got %0d", e.avg_blue, a.avg_blue);
      errors++;
    end
    if (a.avg_ambient !== e.avg_ambient) begin
      $error("avg_ambient: expected %0d, got %0d", e.avg_ambient, a.avg_ambient);
      errors++;
    end
  endtask

  // Input monitor: every accepted item feeds the predictor.
  always @(posedge clk) begin
    out_item_t res;
    if (rst_n && in_valid && in_ready) begin
      n_items++;
      if (classify_item(in_item, res)) begin
        class_q.push_back(res);
        typed_v.push_back(cur_has_exp);
        typed_q.push_back(cur_exp);
      end
    end
  end

  // Output checker: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t e;
    out_item_t te;
    logic      tv;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (out_item.matched) n_hits++;
      if (class_q.size() == 0) begin
        $error("unexpected result item %h", out_item);
        errors++;
      end else begin
        e = class_q.pop_front();
        tv = typed_v.pop_front();
        te = typed_q.pop_front();
        check_fields(e, out_item);
        // Typed-in rows double-check the predictor itself.
        if (tv === 1'b1) check_fields(te, out_item);
      end
    end
  end

  // Result side: ready in random cycles, with short stalls and a few long ones.
  always @(posedge clk) begin
    int r;
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_ready <= 1'b1;
      end else if (r < 93) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(10, 60);
      end
    end
  end

  // Watchdog: counts cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Send one item and hold it until accepted, then maybe leave a gap.
  task automatic send_item(in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 80);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait for every expected result, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (class_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_samples(logic [CNT_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    samples_cfg = v;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t load_item(int idx, int r, int g, int b, int t);
    in_item_t it;
    it = '0;
    it.command = CMD_LOAD;
    it.entry_index = IDX_W'(idx);
    it.ref_red_pct = PCT_W'(r);
    it.ref_green_pct = PCT_W'(g);
    it.ref_blue_pct = PCT_W'(b);
    it.tolerance_pct = PCT_W'(t);
    return it;
  endfunction

  function automatic in_item_t read_item(int r, int g, int b, int a);
    in_item_t it;
    logic [95:0] noise;
    noise = {$urandom(), $urandom(), $urandom()};
    it = noise[$bits(in_item_t)-1:0];
    it.command = CMD_READ;
    it.raw_red = RAW_W'(r);
    it.raw_green = RAW_W'(g);
    it.raw_blue = RAW_W'(b);
    it.raw_ambient = RAW_W'(a);
    return it;
  endfunction

  function automatic in_item_t random_load();
    in_item_t it;
    int r;
    r = $urandom_range(0, 100);
    it = load_item($urandom_range(0, 9), r, $urandom_range(0, 100 - r), 0,
                   $urandom_range(0, 30));
    it.ref_blue_pct = PCT_W'(100 - r - int'(it.ref_green_pct));
    if ($urandom_range(0, 9) == 0) it.entry_index = IDX_W'($urandom_range(10, 15));
    if ($urandom_range(0, 9) == 0) it.tolerance_pct = PCT_W'($urandom_range(0, 127));
    if ($urandom_range(0, 19) == 0) it.ref_red_pct = PCT_W'($urandom_range(0, 127));
    return it;
  endfunction

  function automatic out_item_t typed(logic m, int c, int r, int g, int b, int a);
    out_item_t o;
    o = '{m, c[IDX_W-1:0], r[RAW_W-1:0], g[RAW_W-1:0], b[RAW_W-1:0], a[RAW_W-1:0]};
    return o;
  endfunction

  initial begin
    dir_row_t   rows[$];
    dir_row_t   row;
    logic [CNT_W-1:0] settings[6];

    ref_table = '{default: '0};
    sum_r = 0; sum_g = 0; sum_b = 0; sum_a = 0;
    taken = '0;
    samples_cfg = DEFAULT_SAMPLES;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset count of five. A table of zeros never
    // matches, so the first average comes out as no class.
    for (int i = 0; i < 4; i++) begin
      row.item = read_item(1023, 1023, 1023, 1023); row.has_exp = 0; rows.push_back(row);
    end
    row.item = read_item(1023, 1023, 1023, 1023); row.has_exp = 1;
    row.exp = typed(0, 0, 1023, 1023, 1023, 1023); rows.push_back(row);
    // Zero RGB sum: no class, but the ambient average is still reported.
    for (int i = 0; i < 4; i++) begin
      row.item = read_item(0, 0, 0, 1023); row.has_exp = 0; rows.push_back(row);
    end
    row.item = read_item(0, 0, 0, 1022); row.has_exp = 1;
    row.exp = typed(0, 0, 0, 0, 0, 1022); rows.push_back(row);
    // Loads: entry at the far end, index out of range, extreme tolerances.
    row.has_exp = 0;
    row.item = load_item(9, 33, 33, 33, 1);   rows.push_back(row);
    row.item = load_item(15, 0, 0, 0, 127);   rows.push_back(row);
    row.item = load_item(10, 33, 33, 33, 100); rows.push_back(row);
    row.item = load_item(0, 100, 0, 0, 0);    rows.push_back(row);
    row.item = load_item(1, 127, 127, 127, 127); rows.push_back(row);
    // Pure red hits entry 0 exactly; the 341/682/1 reading falls through to the wide entry 1.
    for (int i = 0; i < 4; i++) begin
      row.item = read_item(1023, 0, 0, 512); rows.push_back(row);
    end
    row.item = read_item(1023, 0, 0, 512); row.has_exp = 1;
    row.exp = typed(1, 0, 1023, 0, 0, 512); rows.push_back(row);
    row.has_exp = 0;
    for (int i = 0; i < 5; i++) begin
      row.item = read_item(341, 682, 1, 0); rows.push_back(row);
    end

    foreach (rows[i]) begin
      cur_has_exp <= rows[i].has_exp;
      cur_exp <= rows[i].exp;
      send_item(rows[i].item);
    end
    cur_has_exp <= 1'b0;
    drain();

    // Random part through several sample counts, the extremes among them.
    // Lowering the count mid-average is covered by the unfinished readings
    // that each phase leaves behind.
    settings = '{7'd1, 7'd64, 7'd0, 7'd3, 7'd127, 7'd2};
    foreach (settings[s]) begin
      int count;
      write_samples(settings[s]);
      count = (settings[s] >= 64) ? 300 : 320;
      for (int k = 0; k < count; k++) begin
        if ($urandom_range(0, 9) < 2) begin
          send_item(random_load());
        end else if ($urandom_range(0, 9) < 6) begin
          // Readings near a loaded color so that entries match often.
          int e;
          in_item_t it;
          e = $urandom_range(0, 9);
          it = read_item(ref_table[e].red * 10 + $urandom_range(0, 23),
                         ref_table[e].green * 10 + $urandom_range(0, 23),
                         ref_table[e].blue * 10 + $urandom_range(0, 23),
                         $urandom_range(0, 1023));
          send_item(it);
        end else begin
          send_item(read_item($urandom_range(0, 1023), $urandom_range(0, 1023),
                              $urandom_range(0, 1023), $urandom_range(0, 1023)));
        end
      end
      drain();
    end

    $display("Covered %0d input items and %0d results, %0d of them classified,",
             n_items, n_results, n_hits);
    $display("over sample counts 0, 1, 2, 3, 5, 64 and 127.");
    if (errors == 0 && class_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/ccc_pkg.sv
src/ccc_datapath.sv
src/ccc_ctrl.sv
src/chromaticity_color_classifier.sv
tb/chromaticity_color_classifier_tb.sv
